// ----- rtl/tcps_pkg.sv -----
// Shared types, constants and helpers for the credit-driven packet shaper.
// Used by every module under rtl/; depends on nothing.
package tcps_pkg;

    localparam int QUEUE_DEPTH     = 32;
    localparam int TOKEN_FRAC_BITS = 8;
    localparam int HANDLE_BITS     = 12;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [11:0] HANDLE_MASK = 12'((33'd1 << HANDLE_BITS) - 33'd1);

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_DROPPED  = 2'd1;
    localparam logic [1:0] KIND_SENT     = 2'd2;
    localparam logic [1:0] KIND_IDLE     = 2'd3;

    typedef struct packed {
        logic        opcode;
        logic [11:0] pkt_handle;
        logic [15:0] pkt_size;
        logic [23:0] credit_amount;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [11:0] sent_handle;
        logic [15:0] sent_size;
        logic [31:0] tokens_left;
        logic [5:0]  queue_level;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [11:0] handle;
        logic [15:0] size;
    } t_entry;

    // command handed from the front part to the back part
    typedef struct packed {
        logic        valid;
        logic        opcode;
        logic [11:0] handle;
        logic [15:0] size;
        logic [23:0] credit;
    } t_cmd;

    function automatic logic [5:0] to_level(input logic [CNT_W-1:0] c);
        logic [CNT_W+5:0] w;
        begin
            w = (CNT_W + 6)'(c);
            return w[5:0];
        end
    endfunction

endpackage

// ----- rtl/tcps_front.sv -----
// Front part: accepts input beats, classifies them into commands and holds
// them in a two-entry queue for the back part. Depends on tcps_pkg.
module tcps_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tcps_pkg::t_in_item i_in_item,
    output tcps_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_take
);

    tcps_pkg::t_cmd r_q [2];
    logic           r_wp, n_wp;
    logic           r_rp, n_rp;
    logic [1:0]     r_cnt, n_cnt;
    tcps_pkg::t_cmd w_cmd;
    logic           w_push;

    assign full   = (r_cnt == 2'd2);
    assign w_push = push && !full;

    always_comb begin
        w_cmd.valid  = 1'b1;
        w_cmd.opcode = i_in_item.opcode;
        // mask the handle to the HANDLE_BITS bits the buffer keeps
        w_cmd.handle = i_in_item.pkt_handle & tcps_pkg::HANDLE_MASK;
        w_cmd.size   = i_in_item.pkt_size;
        w_cmd.credit = i_in_item.credit_amount;
    end

    always_comb begin
        o_cmd       = r_q[r_rp];
        o_cmd.valid = (r_cnt != 2'd0);
    end

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = i_cmd_take ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(w_push) - 2'(i_cmd_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// ----- rtl/tcps_back.sv -----
// Back part: packet buffer memory, token counter and the drain sequencer
// that turns each command into result beats. Depends on tcps_pkg.
module tcps_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcps_pkg::t_cmd      i_cmd,
    output logic                o_cmd_take,
    input  logic                i_res_space,
    output logic                o_res_push,
    output tcps_pkg::t_out_item o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_CHK  = 2'd2;

    logic [1:0]                     r_state, n_state;
    logic [31:0]                    r_tok, n_tok;
    logic [tcps_pkg::PTR_W-1:0]     r_wp, n_wp;
    logic [tcps_pkg::PTR_W-1:0]     r_rp, n_rp;
    logic [tcps_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                           r_pend_v, n_pend_v;
    tcps_pkg::t_out_item            r_pend, n_pend;

    tcps_pkg::t_entry r_mem [tcps_pkg::QUEUE_DEPTH];
    tcps_pkg::t_entry r_rdata;
    logic             w_we;

    logic [32:0] w_sum;
    logic [31:0] w_sat;
    logic [31:0] w_cost;
    logic        w_afford;

    assign w_sum  = {1'b0, r_tok} + 33'(i_cmd.credit);
    assign w_sat  = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
    assign w_cost = 32'(r_rdata.size) << tcps_pkg::TOKEN_FRAC_BITS;
    assign w_afford = (r_cnt != '0) && (r_tok >= w_cost);

    always_comb begin
        n_state    = r_state;
        n_tok      = r_tok;
        n_wp       = r_wp;
        n_rp       = r_rp;
        n_cnt      = r_cnt;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        o_cmd_take = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        w_we       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid && i_res_space) begin
                    o_cmd_take = 1'b1;
                    if (i_cmd.opcode == tcps_pkg::OP_ENQUEUE) begin
                        o_res_push = 1'b1;
                        o_res.last = 1'b1;
                        if (r_cnt == tcps_pkg::CNT_W'(tcps_pkg::QUEUE_DEPTH)) begin
                            o_res.result_kind = tcps_pkg::KIND_DROPPED;
                            o_res.tokens_left = r_tok;
                            o_res.queue_level = tcps_pkg::to_level(r_cnt);
                        end else begin
                            w_we  = 1'b1;
                            n_wp  = (r_wp == tcps_pkg::PTR_W'(tcps_pkg::QUEUE_DEPTH - 1)) ?
                                    '0 : r_wp + 1'b1;
                            n_cnt = r_cnt + 1'b1;
                            o_res.result_kind = tcps_pkg::KIND_ACCEPTED;
                            o_res.tokens_left = r_tok;
                            o_res.queue_level = tcps_pkg::to_level(n_cnt);
                        end
                    end else begin
                        n_tok = w_sat;
                        if (r_cnt == '0) begin
                            o_res_push        = 1'b1;
                            o_res.result_kind = tcps_pkg::KIND_IDLE;
                            o_res.tokens_left = w_sat;
                            o_res.queue_level = tcps_pkg::to_level(r_cnt);
                            o_res.last        = 1'b1;
                        end else begin
                            n_pend_v = 1'b0;
                            n_state  = ST_RD;
                        end
                    end
                end
            end
            ST_RD: begin
                // wait for the head entry to come out of the memory
                n_state = ST_CHK;
            end
            ST_CHK: begin
                if (w_afford) begin
                    // hold the new beat back until we know whether it is the last
                    if (!r_pend_v || i_res_space) begin
                        o_res_push = r_pend_v;
                        o_res      = r_pend;
                        n_cnt      = r_cnt - 1'b1;
                        n_tok      = (r_cnt == tcps_pkg::CNT_W'(1)) ? 32'd0 : r_tok - w_cost;
                        n_rp       = (r_rp == tcps_pkg::PTR_W'(tcps_pkg::QUEUE_DEPTH - 1)) ?
                                     '0 : r_rp + 1'b1;
                        n_pend_v   = 1'b1;
                        n_pend.result_kind = tcps_pkg::KIND_SENT;
                        n_pend.sent_handle = r_rdata.handle;
                        n_pend.sent_size   = r_rdata.size;
                        n_pend.tokens_left = n_tok;
                        n_pend.queue_level = tcps_pkg::to_level(n_cnt);
                        n_pend.last        = 1'b0;
                        n_state    = ST_RD;
                    end
                end else if (i_res_space) begin
                    o_res_push = 1'b1;
                    if (r_pend_v) begin
                        o_res = r_pend;
                    end else begin
                        o_res.result_kind = tcps_pkg::KIND_IDLE;
                        o_res.tokens_left = r_tok;
                        o_res.queue_level = tcps_pkg::to_level(r_cnt);
                    end
                    o_res.last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_tok    <= 32'd0;
            r_wp     <= '0;
            r_rp     <= '0;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tok    <= n_tok;
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_cnt    <= n_cnt;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_wp] <= '{handle: i_cmd.handle, size: i_cmd.size};
        end
        r_rdata <= r_mem[r_rp];
    end

endmodule

// ----- rtl/tcps_outq.sv -----
// Result queue: two entries between the back part and the result port,
// so the back part keeps working while a beat waits. Depends on tcps_pkg.
module tcps_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tcps_pkg::t_out_item i_item,
    output logic                o_space,
    output logic                empty,
    input  logic                pop,
    output tcps_pkg::t_out_item o_item
);

    tcps_pkg::t_out_item r_q [2];
    logic                r_wp, r_rp;
    logic [1:0]          r_cnt;
    logic                w_pop;
    logic                w_push;

    assign empty   = (r_cnt == 2'd0);
    assign o_space = (r_cnt != 2'd2);
    assign o_item  = r_q[r_rp];
    assign w_pop   = pop && !empty;
    assign w_push  = i_push && o_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= w_push ? ~r_wp : r_wp;
            r_rp  <= w_pop ? ~r_rp : r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_item;
        end
    end

endmodule

// ----- rtl/trace_credit_packet_shaper.sv -----
// Top level of the credit-driven packet shaper: front queue, back sequencer
// and result queue. Depends on tcps_pkg, tcps_front, tcps_back, tcps_outq.
//
//  channel | handshake       | beat
//  --------+-----------------+------------------------------------------
//  input   | push / full     | i_in_item  (tcps_pkg::t_in_item)
//  result  | pop / empty     | o_out_item (tcps_pkg::t_out_item)
//
// An enqueue, or a tick on an empty queue, is handled in the idle state. Any
// other tick adds credit there, then for each released packet reads the buffer
// memory and then compares and subtracts, and at last reads the head that
// stops the drain, or finds the queue empty, and closes.
// Reset is synchronous, active low; the buffer contents are not cleared.
// A two-entry command queue and a two-entry result queue let input and
// result sides stall independently of the sequencer.
module trace_credit_packet_shaper (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  tcps_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output tcps_pkg::t_out_item o_out_item
);

    tcps_pkg::t_cmd      w_cmd;
    logic                w_cmd_take;
    logic                w_res_space;
    logic                w_res_push;
    tcps_pkg::t_out_item w_res;

    tcps_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .o_cmd      (w_cmd),
        .i_cmd_take (w_cmd_take)
    );

    tcps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .i_res_space (w_res_space),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    tcps_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_item  (w_res),
        .o_space (w_res_space),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_out_item)
    );

endmodule
